[rtl/assert_macros.svh]
// assertion macros shared by the tracklet overlap block
// no dependencies; included by the top level only
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[rtl/tos_pkg.sv]
// shared constants, request codes and types of the tracklet overlap block
// no dependencies; used by the top level, front, back and testbench
`timescale 1ns / 1ps

package tos_pkg;

    localparam int FRAME_BITS      = 12;
    localparam int COUNT_BITS      = 13;
    localparam int EPOCH_BITS      = 8;
    localparam int DEF_FRAME_SLOTS = 4096;
    localparam int DEF_COORD_BITS  = 12;
    // power of two so the queue pointers wrap on their own
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] REQ_STORE   = 2'd0;
    localparam logic [1:0] REQ_COMPARE = 2'd1;
    localparam logic [1:0] REQ_FINISH  = 2'd2;

    // back part to front part
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_status_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
        return r;
    endfunction

endpackage

[rtl/tracklet_overlap_similarity_top.sv]
// tracklet overlap similarity: top level joining the request front part
// and the table back part; uses tos_pkg, tos_front, tos_back, assert_macros.svh
//
// input channel (in_valid / in_stall): one request per accept. req_type 0
//   stores a reference box for its frame, 1 compares a candidate box against
//   the stored box of the same frame, 2 closes the epoch, 3 is dropped.
// output channel (out_valid / out_stall): one result per finish request,
//   carrying the verdict and the three frame counts of the closed epoch.
// a two-entry request queue sits between the front and the back, and the
//   result sits in an output register, so requests keep flowing while a
//   result waits on out_stall; only a finish waits for the register to free.
// steps in the back sequencer: a store reads then writes the table; a
//   candidate reads it and, with a stored box, goes on to the sides, area
//   multiplies and compare; a finish is taken in idle. a request is poppable
//   in the cycle after its accept; a finish result is registered on its pop.
// throughput is set by the back sequencer, which takes one request at a time.
// after reset the back writes every table tag, one slot a cycle, with in_stall
//   high; the same sweep runs after every 255th finish when the 8-bit epoch
//   tag wraps.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tracklet_overlap_similarity_top #(
    parameter int FRAME_SLOTS = tos_pkg::DEF_FRAME_SLOTS,
    parameter int COORD_BITS  = tos_pkg::DEF_COORD_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     req_type,
    input  logic [tos_pkg::FRAME_BITS-1:0] frame,
    input  logic [COORD_BITS-1:0]          left,
    input  logic [COORD_BITS-1:0]          top,
    input  logic [COORD_BITS-1:0]          right,
    input  logic [COORD_BITS-1:0]          bottom,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           similar,
    output logic [tos_pkg::COUNT_BITS-1:0] reference_frames,
    output logic [tos_pkg::COUNT_BITS-1:0] candidate_frames,
    output logic [tos_pkg::COUNT_BITS-1:0] overlap_frames
);

    localparam int SLOT_BITS = $clog2(FRAME_SLOTS);

    tos_pkg::back_status_t   status;
    logic                    q_valid;
    logic [1:0]              q_kind;
    logic [SLOT_BITS-1:0]    q_slot;
    logic [4*COORD_BITS-1:0] q_box;

    tos_front #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .COORD_BITS  (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .frame    (frame),
        .left     (left),
        .top      (top),
        .right    (right),
        .bottom   (bottom),
        .status   (status),
        .q_valid  (q_valid),
        .q_kind   (q_kind),
        .q_slot   (q_slot),
        .q_box    (q_box)
    );

    tos_back #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_kind           (q_kind),
        .q_slot           (q_slot),
        .q_box            (q_box),
        .status           (status),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .similar          (similar),
        .reference_frames (reference_frames),
        .candidate_frames (candidate_frames),
        .overlap_frames   (overlap_frames)
    );

    // no request gets in while the tag sweep runs
    `ASSERT_IMPLIES(a_no_accept_in_sweep, clk, rst_n, status.clearing, in_stall)
    // the back never pops an empty queue
    `ASSERT_IMPLIES(a_pop_needs_item, clk, rst_n, status.pop, q_valid)
    // a popped finish request always lands in the output register
    `ASSERT_NEXT(a_finish_gives_result, clk, rst_n,
        status.pop && (q_kind == tos_pkg::REQ_FINISH), out_valid)
    // overlaps are only counted on candidates
    `ASSERT_IMPLIES(a_overlap_bounded, clk, rst_n, out_valid,
        overlap_frames <= candidate_frames)

endmodule

[rtl/tos_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tos_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tos_front.sv]
// front part: takes requests, drops unknown codes, maps frames to slots,
// and queues them for the back part; uses tos_pkg
`timescale 1ns / 1ps

module tos_front #(
    parameter int FRAME_SLOTS = tos_pkg::DEF_FRAME_SLOTS,
    parameter int COORD_BITS  = tos_pkg::DEF_COORD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [tos_pkg::FRAME_BITS-1:0]    frame,
    input  logic [COORD_BITS-1:0]             left,
    input  logic [COORD_BITS-1:0]             top,
    input  logic [COORD_BITS-1:0]             right,
    input  logic [COORD_BITS-1:0]             bottom,
    input  tos_pkg::back_status_t             status,
    output logic                              q_valid,
    output logic [1:0]                        q_kind,
    output logic [$clog2(FRAME_SLOTS)-1:0]    q_slot,
    output logic [4*COORD_BITS-1:0]           q_box
);

    localparam int SLOT_BITS = $clog2(FRAME_SLOTS);
    localparam int BOX_BITS  = 4 * COORD_BITS;
    localparam int PTR_BITS  = $clog2(tos_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS  = $clog2(tos_pkg::QUEUE_DEPTH + 1);
    localparam int WIDE_BITS = tos_pkg::FRAME_BITS + SLOT_BITS;

    logic [1:0]           kind_q [tos_pkg::QUEUE_DEPTH];
    logic [SLOT_BITS-1:0] slot_q [tos_pkg::QUEUE_DEPTH];
    logic [BOX_BITS-1:0]  box_q  [tos_pkg::QUEUE_DEPTH];

    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;

    logic                 full;
    logic                 known;
    logic                 push;
    logic [WIDE_BITS-1:0] frame_wide;
    logic [SLOT_BITS-1:0] slot;

    // table depth is a power of two, so the slot is the low frame bits
    assign frame_wide = WIDE_BITS'(frame);
    assign slot       = frame_wide[SLOT_BITS-1:0];

    assign full     = (cnt_reg == CNT_BITS'(tos_pkg::QUEUE_DEPTH));
    assign in_stall = full || status.clearing;
    assign known    = (req_type == tos_pkg::REQ_STORE) ||
                      (req_type == tos_pkg::REQ_COMPARE) ||
                      (req_type == tos_pkg::REQ_FINISH);
    assign push     = in_valid && !in_stall && known;

    assign wr_ptr_next = push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
    assign rd_ptr_next = status.pop ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
    assign cnt_next    = cnt_reg + CNT_BITS'(push) - CNT_BITS'(status.pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_q[wr_ptr_reg] <= req_type;
            slot_q[wr_ptr_reg] <= slot;
            box_q[wr_ptr_reg]  <= {left, top, right, bottom};
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_kind  = kind_q[rd_ptr_reg];
    assign q_slot  = slot_q[rd_ptr_reg];
    assign q_box   = box_q[rd_ptr_reg];

endmodule

[rtl/tos_back.sv]
// back part: sequencer over the epoch-tagged box table, area multiplies,
// counters, verdict and output register; uses tos_pkg and tos_ram
`timescale 1ns / 1ps

module tos_back #(
    parameter int FRAME_SLOTS = tos_pkg::DEF_FRAME_SLOTS,
    parameter int COORD_BITS  = tos_pkg::DEF_COORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    input  logic [1:0]                         q_kind,
    input  logic [$clog2(FRAME_SLOTS)-1:0]     q_slot,
    input  logic [4*COORD_BITS-1:0]            q_box,
    output tos_pkg::back_status_t              status,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               similar,
    output logic [tos_pkg::COUNT_BITS-1:0]     reference_frames,
    output logic [tos_pkg::COUNT_BITS-1:0]     candidate_frames,
    output logic [tos_pkg::COUNT_BITS-1:0]     overlap_frames
);

    localparam int SLOT_BITS  = $clog2(FRAME_SLOTS);
    localparam int BOX_BITS   = 4 * COORD_BITS;
    localparam int EB         = tos_pkg::EPOCH_BITS;
    localparam int ENTRY_BITS = EB + BOX_BITS;
    localparam int DIM_BITS   = COORD_BITS + 1;
    localparam int AREA_BITS  = 2 * DIM_BITS;
    localparam int CB         = tos_pkg::COUNT_BITS;
    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(FRAME_SLOTS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MULT  = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [SLOT_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [EB-1:0]        epoch_reg, epoch_next;
    logic [CB-1:0]        ref_cnt_reg, ref_cnt_next;
    logic [CB-1:0]        cand_cnt_reg, cand_cnt_next;
    logic [CB-1:0]        ov_cnt_reg, ov_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    logic [1:0]           cur_kind_reg;
    logic [SLOT_BITS-1:0] cur_slot_reg;
    logic [BOX_BITS-1:0]  cur_box_reg;
    logic [DIM_BITS-1:0]  wr_reg, hr_reg, wc_reg, hc_reg, wi_reg, hi_reg;
    logic [AREA_BITS-1:0] ar_reg, ac_reg, ai_reg;
    logic                 similar_reg;
    logic [CB-1:0]        ref_out_reg, cand_out_reg, ov_out_reg;

    logic                 pop, load_cur, load_dims, load_out;
    logic                 ram_we;
    logic [SLOT_BITS-1:0] ram_waddr;
    logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;
    logic [EB-1:0]        epoch_inc;
    logic                 out_free;

    logic [EB-1:0]         rd_tag;
    logic [BOX_BITS-1:0]   rd_box;
    logic                  hit;
    logic [COORD_BITS-1:0] rl, rt, rr, rb, cl, ct, cr, cb;
    logic [COORD_BITS-1:0] il, it, ir, ib;
    logic                  ref_ok, cand_ok, int_ok;
    logic [DIM_BITS-1:0]   wr_w, hr_w, wc_w, hc_w, wi_w, hi_w;
    logic [AREA_BITS-1:0]  area_min;
    logic                  big_overlap;

    logic [CB-1:0]         n_min, n_diff;
    logic                  verdict;

    tos_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (FRAME_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (q_slot),
        .rdata (ram_rdata)
    );

    // table read comes back in the cycle after the pop
    assign rd_tag = ram_rdata[ENTRY_BITS-1 -: EB];
    assign rd_box = ram_rdata[BOX_BITS-1:0];
    assign hit    = (rd_tag == epoch_reg);

    assign rl = rd_box[4*COORD_BITS-1 -: COORD_BITS];
    assign rt = rd_box[3*COORD_BITS-1 -: COORD_BITS];
    assign rr = rd_box[2*COORD_BITS-1 -: COORD_BITS];
    assign rb = rd_box[COORD_BITS-1:0];
    assign cl = cur_box_reg[4*COORD_BITS-1 -: COORD_BITS];
    assign ct = cur_box_reg[3*COORD_BITS-1 -: COORD_BITS];
    assign cr = cur_box_reg[2*COORD_BITS-1 -: COORD_BITS];
    assign cb = cur_box_reg[COORD_BITS-1:0];

    assign ref_ok  = (rr >= rl) && (rb >= rt);
    assign cand_ok = (cr >= cl) && (cb >= ct);
    assign il = (rl > cl) ? rl : cl;
    assign it = (rt > ct) ? rt : ct;
    assign ir = (rr < cr) ? rr : cr;
    assign ib = (rb < cb) ? rb : cb;
    assign int_ok = ref_ok && cand_ok && (il <= ir) && (it <= ib);

    // inverted boxes and disjoint pairs get zero sides, hence zero area
    assign wr_w = ref_ok  ? {1'b0, rr} - {1'b0, rl} + DIM_BITS'(1) : '0;
    assign hr_w = ref_ok  ? {1'b0, rb} - {1'b0, rt} + DIM_BITS'(1) : '0;
    assign wc_w = cand_ok ? {1'b0, cr} - {1'b0, cl} + DIM_BITS'(1) : '0;
    assign hc_w = cand_ok ? {1'b0, cb} - {1'b0, ct} + DIM_BITS'(1) : '0;
    assign wi_w = int_ok  ? {1'b0, ir} - {1'b0, il} + DIM_BITS'(1) : '0;
    assign hi_w = int_ok  ? {1'b0, ib} - {1'b0, it} + DIM_BITS'(1) : '0;

    assign area_min    = (ar_reg < ac_reg) ? ar_reg : ac_reg;
    assign big_overlap = (ai_reg > (area_min >> 3));

    assign n_min   = (ref_cnt_reg < cand_cnt_reg) ? ref_cnt_reg : cand_cnt_reg;
    assign n_diff  = (ref_cnt_reg > cand_cnt_reg) ? ref_cnt_reg - cand_cnt_reg
                                                  : cand_cnt_reg - ref_cnt_reg;
    assign verdict = (n_diff <= (n_min >> 2)) && (ov_cnt_reg != '0) &&
                     (ov_cnt_reg >= (n_min >> 3));

    assign epoch_inc = epoch_reg + EB'(1);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        epoch_next     = epoch_reg;
        ref_cnt_next   = ref_cnt_reg;
        cand_cnt_next  = cand_cnt_reg;
        ov_cnt_next    = ov_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        pop            = 1'b0;
        load_cur       = 1'b0;
        load_dims      = 1'b0;
        load_out       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cur_slot_reg;
        ram_wdata      = {epoch_reg, cur_box_reg};
        case (state_reg)
            ST_CLEAR:
            begin
                // tag 0 is never a live epoch
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + SLOT_BITS'(1);
                if (clr_addr_reg == SLOT_LAST)
                begin
                    epoch_next = EB'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_kind == tos_pkg::REQ_FINISH)
                    begin
                        if (out_free)
                        begin
                            pop            = 1'b1;
                            load_out       = 1'b1;
                            out_valid_next = 1'b1;
                            ref_cnt_next   = '0;
                            cand_cnt_next  = '0;
                            ov_cnt_next    = '0;
                            if (epoch_inc == '0)
                            begin
                                clr_addr_next = '0;
                                state_next    = ST_CLEAR;
                            end
                            else
                            begin
                                epoch_next = epoch_inc;
                            end
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        load_cur   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (cur_kind_reg == tos_pkg::REQ_STORE)
                begin
                    ram_we = 1'b1;
                    if (!hit)
                    begin
                        ref_cnt_next = tos_pkg::sat_inc(ref_cnt_reg);
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    cand_cnt_next = tos_pkg::sat_inc(cand_cnt_reg);
                    if (hit)
                    begin
                        load_dims  = 1'b1;
                        state_next = ST_MULT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MULT:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (big_overlap)
                begin
                    ov_cnt_next = tos_pkg::sat_inc(ov_cnt_reg);
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            epoch_reg     <= EB'(1);
            ref_cnt_reg   <= '0;
            cand_cnt_reg  <= '0;
            ov_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            epoch_reg     <= epoch_next;
            ref_cnt_reg   <= ref_cnt_next;
            cand_cnt_reg  <= cand_cnt_next;
            ov_cnt_reg    <= ov_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_cur)
        begin
            cur_kind_reg <= q_kind;
            cur_slot_reg <= q_slot;
            cur_box_reg  <= q_box;
        end
        if (load_dims)
        begin
            wr_reg <= wr_w;
            hr_reg <= hr_w;
            wc_reg <= wc_w;
            hc_reg <= hc_w;
            wi_reg <= wi_w;
            hi_reg <= hi_w;
        end
        ar_reg <= wr_reg * hr_reg;
        ac_reg <= wc_reg * hc_reg;
        ai_reg <= wi_reg * hi_reg;
        if (load_out)
        begin
            similar_reg  <= verdict;
            ref_out_reg  <= ref_cnt_reg;
            cand_out_reg <= cand_cnt_reg;
            ov_out_reg   <= ov_cnt_reg;
        end
    end

    assign status.pop      = pop;
    assign status.clearing = (state_reg == ST_CLEAR);

    assign out_valid        = out_valid_reg;
    assign similar          = similar_reg;
    assign reference_frames = ref_out_reg;
    assign candidate_frames = cand_out_reg;
    assign overlap_frames   = ov_out_reg;

endmodule

[sim/testbench.sv]
// self-checking testbench for tracklet_overlap_similarity_top: own track-matching predictor,
// random driver and result monitor on valid/stall channels; depends on tos_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

    localparam int          FRAME_COUNT = tos_pkg::DEF_FRAME_SLOTS;
    localparam int          CW          = tos_pkg::DEF_COORD_BITS;
    localparam int          FB          = tos_pkg::FRAME_BITS;
    localparam int          NB          = tos_pkg::COUNT_BITS;
    localparam int          COORD_TOP   = (1 << CW) - 1;
    localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          TAIL_ITEMS  = 150;

    typedef struct packed {
        logic [1:0]    kind;
        logic [FB-1:0] frame;
        logic [CW-1:0] x0;
        logic [CW-1:0] y0;
        logic [CW-1:0] x1;
        logic [CW-1:0] y1;
    } box_req_t;

    typedef struct packed {
        logic          similar;
        logic [NB-1:0] ref_n;
        logic [NB-1:0] cand_n;
        logic [NB-1:0] hit_n;
    } verdict_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [1:0]    req_type = '0;
    logic [FB-1:0] frame = '0;
    logic [CW-1:0] left = '0;
    logic [CW-1:0] top = '0;
    logic [CW-1:0] right = '0;
    logic [CW-1:0] bottom = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          similar;
    logic [NB-1:0] reference_frames;
    logic [NB-1:0] candidate_frames;
    logic [NB-1:0] overlap_frames;

    tracklet_overlap_similarity_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .frame            (frame),
        .left             (left),
        .top              (top),
        .right            (right),
        .bottom           (bottom),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .similar          (similar),
        .reference_frames (reference_frames),
        .candidate_frames (candidate_frames),
        .overlap_frames   (overlap_frames)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    box_req_t      held_box [FRAME_COUNT];
    bit            held_live [FRAME_COUNT];
    logic [NB-1:0] ref_n = '0;
    logic [NB-1:0] cand_n = '0;
    logic [NB-1:0] hit_n = '0;

    box_req_t pending [$];
    verdict_t verdicts_due [$];
    int       queued = 0;
    int       errors = 0;
    int       cycles = 0;
    int       idle_pct = 0;
    bit       quiet_tail = 1'b0;
    int       gap_left = 0;
    int       hold_left = 0;

    function automatic logic [NB-1:0] count_up(input logic [NB-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic longint unsigned span(input int lo, input int hi);
        return (hi >= lo) ? longint'(hi - lo + 1) : 64'd0;
    endfunction

    function automatic longint unsigned box_area(input box_req_t b);
        return span(int'(b.x0), int'(b.x1)) * span(int'(b.y0), int'(b.y1));
    endfunction

    // an inverted side on either box makes one of the spans empty
    function automatic longint unsigned shared_area(input box_req_t a, input box_req_t c);
        int lo_x, hi_x, lo_y, hi_y;
        lo_x = (a.x0 > c.x0) ? int'(a.x0) : int'(c.x0);
        hi_x = (a.x1 < c.x1) ? int'(a.x1) : int'(c.x1);
        lo_y = (a.y0 > c.y0) ? int'(a.y0) : int'(c.y0);
        hi_y = (a.y1 < c.y1) ? int'(a.y1) : int'(c.y1);
        if (a.x1 < a.x0 || a.y1 < a.y0 || c.x1 < c.x0 || c.y1 < c.y0)
            return 64'd0;
        return span(lo_x, hi_x) * span(lo_y, hi_y);
    endfunction

    function automatic void update_tracks(input box_req_t rq);
        longint unsigned least, ra, ca;
        int unsigned     na, nb, mn, diff;
        verdict_t        v;
        case (rq.kind)
            tos_pkg::REQ_STORE:
            begin
                if (!held_live[rq.frame])
                begin
                    ref_n = count_up(ref_n);
                    held_live[rq.frame] = 1'b1;
                end
                held_box[rq.frame] = rq;
            end
            tos_pkg::REQ_COMPARE:
            begin
                cand_n = count_up(cand_n);
                if (held_live[rq.frame])
                begin
                    ra = box_area(held_box[rq.frame]);
                    ca = box_area(rq);
                    least = (ra < ca) ? ra : ca;
                    if (shared_area(held_box[rq.frame], rq) > least / 8)
                        hit_n = count_up(hit_n);
                end
            end
            tos_pkg::REQ_FINISH:
            begin
                na = ref_n;
                nb = cand_n;
                mn = (na < nb) ? na : nb;
                diff = (na > nb) ? na - nb : nb - na;
                v.similar = (diff <= mn / 4) && (hit_n >= 1) && (hit_n >= mn / 8);
                v.ref_n = ref_n;
                v.cand_n = cand_n;
                v.hit_n = hit_n;
                verdicts_due.push_back(v);
                foreach (held_live[i])
                    held_live[i] = 1'b0;
                ref_n = '0;
                cand_n = '0;
                hit_n = '0;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    function automatic logic [CW-1:0] fit_coord(input int v);
        return (v < 0) ? '0 : (v > COORD_TOP) ? CW'(COORD_TOP) : CW'(v);
    endfunction

    function automatic box_req_t pack_request(input logic [1:0] kind, input int f,
                                              input int x0, input int y0,
                                              input int x1, input int y1);
        box_req_t r;
        r.kind = kind;
        r.frame = FB'(f);
        r.x0 = CW'(x0);
        r.y0 = CW'(y0);
        r.x1 = CW'(x1);
        r.y1 = CW'(y1);
        return r;
    endfunction

    function automatic box_req_t rand_box();
        box_req_t b;
        int       pick, w, h;
        pick = $urandom_range(0, 99);
        b.kind = tos_pkg::REQ_STORE;
        b.frame = '0;
        if (pick < 6)
        begin
            // unconstrained corners, often inverted
            b.x0 = CW'($urandom_range(0, COORD_TOP));
            b.y0 = CW'($urandom_range(0, COORD_TOP));
            b.x1 = CW'($urandom_range(0, COORD_TOP));
            b.y1 = CW'($urandom_range(0, COORD_TOP));
        end
        else if (pick < 10)
        begin
            b.x0 = $urandom_range(0, 1) ? '0 : CW'(COORD_TOP);
            b.y0 = $urandom_range(0, 1) ? '0 : CW'(COORD_TOP);
            b.x1 = CW'(COORD_TOP);
            b.y1 = CW'(COORD_TOP);
        end
        else
        begin
            w = $urandom_range(0, (pick < 20) ? COORD_TOP : 200);
            h = $urandom_range(0, (pick < 20) ? COORD_TOP : 200);
            b.x0 = CW'($urandom_range(0, COORD_TOP - w));
            b.y0 = CW'($urandom_range(0, COORD_TOP - h));
            b.x1 = b.x0 + CW'(w);
            b.y1 = b.y0 + CW'(h);
        end
        return b;
    endfunction

    function automatic box_req_t nudge_box(input box_req_t b);
        box_req_t c;
        int       w, h, dx, dy;
        c = b;
        w = ((b.x1 >= b.x0) ? int'(b.x1) - int'(b.x0) : 0) + 8;
        h = ((b.y1 >= b.y0) ? int'(b.y1) - int'(b.y0) : 0) + 8;
        if (w > 400)
            w = 400;
        if (h > 400)
            h = 400;
        dx = int'($urandom_range(0, 2 * w)) - w;
        dy = int'($urandom_range(0, 2 * h)) - h;
        c.x0 = fit_coord(int'(b.x0) + dx);
        c.x1 = fit_coord(int'(b.x1) + dx);
        c.y0 = fit_coord(int'(b.y0) + dy);
        c.y1 = fit_coord(int'(b.y1) + dy);
        return c;
    endfunction

    task automatic queue_request(input box_req_t r);
        pending.push_back(r);
        if (r.kind != REQ_UNKNOWN)
            queued++;
    endtask

    // candidate for a stored box: mostly a shifted copy, sometimes missing,
    // off-frame, repeated, or followed by noise
    task automatic queue_candidate(input box_req_t ref_box);
        box_req_t c;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick >= 8)
        begin
            if (pick < 14)
            begin
                c = rand_box();
                c.frame = FB'($urandom_range(0, FRAME_COUNT - 1));
            end
            else if (pick < 20)
                c = rand_box();
            else
                c = nudge_box(ref_box);
            if (pick >= 14)
                c.frame = ref_box.frame;
            c.kind = tos_pkg::REQ_COMPARE;
            queue_request(c);
            if (pick >= 96)
                queue_request(c);
        end
        if ($urandom_range(0, 99) < 4)
        begin
            c = rand_box();
            c.kind = REQ_UNKNOWN;
            c.frame = FB'($urandom_range(0, FRAME_COUNT - 1));
            queue_request(c);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        box_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
            quiet_tail <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                update_tracks({req_type, frame, left, top, right, bottom});
            quiet_tail <= (pending.size() < TAIL_ITEMS);
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending.size() != 0 && !quiet_tail
                         && $urandom_range(0, 99) < idle_pct)
                begin
                    gap_left <= $urandom_range(0, 3);
                    in_valid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    nxt = pending.pop_front();
                    in_valid <= 1'b1;
                    req_type <= nxt.kind;
                    frame <= nxt.frame;
                    left <= nxt.x0;
                    top <= nxt.y0;
                    right <= nxt.x1;
                    bottom <= nxt.y1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin : observe
        verdict_t seen, want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {similar, reference_frames, candidate_frames, overlap_frames};
                if (verdicts_due.size() == 0)
                    report_mismatch("result with none pending", 0, 1);
                else
                begin
                    want = verdicts_due.pop_front();
                    if (seen.similar !== want.similar)
                        report_mismatch("similar", want.similar, seen.similar);
                    if (seen.ref_n !== want.ref_n)
                        report_mismatch("reference_frames", want.ref_n, seen.ref_n);
                    if (seen.cand_n !== want.cand_n)
                        report_mismatch("candidate_frames", want.cand_n, seen.cand_n);
                    if (seen.hit_n !== want.hit_n)
                        report_mismatch("overlap_frames", want.hit_n, seen.hit_n);
                end
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < idle_pct)
            begin
                hold_left <= $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // cycle count, idle rate changes, run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles % 300 == 0)
            idle_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        if (cycles == CYCLE_LIMIT)
        begin
            $display("run limit reached");
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        box_req_t plan [24];
        box_req_t r;
        int       i, e, n, base, step, order;

        // directed: extremes, inverted boxes, overwrite, repeats, threshold edges
        queue_request(pack_request(tos_pkg::REQ_STORE, 0, 0, 0, 0, 0));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 0, 0, 0, 0, 0));
        queue_request(pack_request(tos_pkg::REQ_STORE, 4095, 0, 0, 4095, 4095));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 4095, 4095, 4095, 4095, 4095));
        queue_request(pack_request(tos_pkg::REQ_STORE, 10, 100, 5, 50, 60));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 10, 0, 0, 4095, 4095));
        queue_request(pack_request(tos_pkg::REQ_STORE, 20, 100, 100, 199, 199));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 20, 100, 300, 199, 200));
        queue_request(pack_request(tos_pkg::REQ_STORE, 20, 0, 0, 9, 9));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 20, 0, 0, 9, 9));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 20, 0, 0, 9, 9));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 30, 0, 0, 4095, 4095));
        queue_request(pack_request(REQ_UNKNOWN, 2730, 1365, 2730, 4095, 0));
        queue_request(pack_request(tos_pkg::REQ_STORE, 40, 0, 0, 7, 0));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 40, 7, 0, 7, 0));
        // overlap of exactly one eighth does not count, one pixel more does
        queue_request(pack_request(tos_pkg::REQ_STORE, 41, 0, 0, 15, 0));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 41, 14, 0, 29, 0));
        queue_request(pack_request(tos_pkg::REQ_STORE, 42, 0, 0, 15, 0));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 42, 13, 0, 28, 0));
        queue_request(pack_request(tos_pkg::REQ_STORE, 50, 0, 0, 9, 9));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 50, 10, 10, 19, 19));
        queue_request(pack_request(tos_pkg::REQ_FINISH, 0, 0, 0, 0, 0));
        queue_request(pack_request(tos_pkg::REQ_COMPARE, 0, 0, 0, 0, 0));
        queue_request(pack_request(tos_pkg::REQ_FINISH, 4095, 4095, 4095, 4095, 4095));
        queue_request(pack_request(tos_pkg::REQ_FINISH, 0, 0, 0, 0, 0));

        // random track pairs, one epoch each
        base = queued;
        while (queued - base < 300)
        begin
            n = $urandom_range(1, 24);
            e = $urandom_range(0, FRAME_COUNT - 1);
            step = $urandom_range(1, 3);
            order = $urandom_range(0, 5);
            for (i = 0; i < n; i++)
            begin
                plan[i] = rand_box();
                plan[i].frame = FB'((e + i * step) % FRAME_COUNT);
            end
            if (order == 0)
                for (i = 0; i < n; i++)
                    queue_candidate(plan[i]);
            for (i = 0; i < n; i++)
            begin
                queue_request(plan[i]);
                if (order == 1 || order == 2)
                    queue_candidate(plan[i]);
                if ($urandom_range(0, 99) < 3)
                begin
                    // overwrite an already stored frame
                    r = rand_box();
                    r.frame = plan[i].frame;
                    plan[i] = r;
                    queue_request(r);
                end
            end
            if (order >= 3)
                for (i = 0; i < n; i++)
                    queue_candidate(plan[i]);
            queue_request(pack_request(tos_pkg::REQ_FINISH,
                                       $urandom_range(0, FRAME_COUNT - 1), 0, 0, 0, 0));
        end

        // many short epochs on a few frames, past the epoch tag wrap
        for (e = 0; e < 260; e++)
        begin
            n = $urandom_range(0, 1);
            for (i = 0; i < n; i++)
            begin
                step = $urandom_range(0, 7);
                queue_request(pack_request($urandom_range(0, 1) ? tos_pkg::REQ_STORE
                                                                : tos_pkg::REQ_COMPARE,
                                           step, step * 8, step * 8,
                                           step * 8 + 20, step * 8 + 20));
            end
            queue_request(pack_request(tos_pkg::REQ_FINISH, 0, 0, 0, 0, 0));
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || in_valid)
            @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
